### hw/rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants for the power-law quantizer pipeline.
// ----------------------------------------------------------------------------
package apq_pkg;

	// Square-root unit: radicand width, root width, one step per stage.
	localparam int SqrtW     = 60;
	localparam int RootW     = SqrtW / 2;
	localparam int SqrtSteps = SqrtW / 2;

	// Scaled magnitude Y = P >> 8 below the clipping threshold.
	localparam int YW = 50;

	// Largest quantized magnitude.
	localparam logic [14:0] QMax = 15'd8191;

	// Fixed latency from start to result strobe.
	localparam int Latency = 2 * SqrtSteps + 5;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GAIN         = 2'd0,
		CFG_ROUND_OFFSET = 2'd1
	} apq_cfg_idx_t;

	// Sideband that rides along with the square-root pipeline.
	typedef struct packed {
		logic          neg;
		logic          last;
		logic          sat;
		logic [YW-1:0] y;
	} apq_side_t;

endpackage

### hw/rtl/apq_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// apq_isqrt_pipe
// Pipelined floor square root, one result bit resolved per register stage.
// ----------------------------------------------------------------------------
module apq_isqrt_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [apq_pkg::SqrtW-1:0]      in_radicand,
	input  apq_pkg::apq_side_t             in_side,
	output logic                           out_valid,
	output logic [apq_pkg::RootW-1:0]      out_root,
	output apq_pkg::apq_side_t             out_side
);

	logic [apq_pkg::SqrtW-1:0] rem_s  [0:apq_pkg::SqrtSteps];
	logic [apq_pkg::SqrtW-1:0] root_s [0:apq_pkg::SqrtSteps];
	logic                      vld_s  [0:apq_pkg::SqrtSteps];
	apq_pkg::apq_side_t        side_s [0:apq_pkg::SqrtSteps];

	// Stage zero is the incoming item itself.
	assign rem_s[0]  = in_radicand;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;

	// Each stage tries one root bit with a compare and subtract.
	for (genvar k = 0; k < apq_pkg::SqrtSteps; k++) begin : g_step
		localparam logic [apq_pkg::SqrtW-1:0] Bit =
			apq_pkg::SqrtW'(1) << (apq_pkg::SqrtW - 2 - 2 * k);
		logic [apq_pkg::SqrtW-1:0] trial;
		logic [apq_pkg::SqrtW-1:0] rem_nxt;
		logic [apq_pkg::SqrtW-1:0] root_nxt;

		always_comb begin
			trial = root_s[k] + Bit;
			if (rem_s[k] >= trial) begin
				rem_nxt  = rem_s[k] - trial;
				root_nxt = (root_s[k] >> 1) + Bit;
			end else begin
				rem_nxt  = rem_s[k];
				root_nxt = root_s[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_nxt;
			root_s[k+1] <= root_nxt;
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[apq_pkg::SqrtSteps];
	assign out_root  = root_s[apq_pkg::SqrtSteps][apq_pkg::RootW-1:0];
	assign out_side  = side_s[apq_pkg::SqrtSteps];

endmodule

### hw/rtl/aac_power_law_quantizer_unit.sv
// ----------------------------------------------------------------------------
// aac_power_law_quantizer_unit
// Three-quarter power-law quantizer for spectral coefficients.
// ----------------------------------------------------------------------------
// Channel  | Signals                                      | Direction
// input    | start, busy, sample, last_of_block           | in (busy out)
// result   | result_valid, quant_value, saturated, last_out | out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | in (ready out)
//
// One item is taken every cycle; busy stays low.
// Each result passes through the two 30-stage square-root pipelines
// plus five arithmetic stages.
// Reset clears all valid bits and loads the default gain and offset.
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module aac_power_law_quantizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] sample,
	input  logic               last_of_block,
	output logic               result_valid,
	output logic signed [13:0] quant_value,
	output logic               saturated,
	output logic               last_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] gain_q;
	logic [15:0] round_offset_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q         <= 32'd16777216;
			round_offset_q <= 16'd26568;
		end else if (cfg_valid) begin
			if (cfg_index == apq_pkg::CFG_GAIN) begin
				gain_q <= cfg_data;
			end else if (cfg_index == apq_pkg::CFG_ROUND_OFFSET) begin
				round_offset_q <= cfg_data[15:0];
			end
		end
	end

	// Stage 1: magnitude and sign.
	logic        vld_s1, neg_s1, last_s1;
	logic [31:0] mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= sample[31];
		last_s1 <= last_of_block;
		mag_s1  <= sample[31] ? (~sample + 32'd1) : sample;
	end

	// Stage 2: scaled product P = |sample| * gain.
	logic        vld_s2, neg_s2, last_s2;
	logic [63:0] p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s2  <= neg_s1;
		last_s2 <= last_s1;
		p_s2    <= 64'(mag_s1) * 64'(gain_q);
	end

	// First square root: S = isqrt(Y).
	apq_pkg::apq_side_t side_a_in, side_a_out;
	logic               vld_a;
	logic [apq_pkg::RootW-1:0] root_a;

	always_comb begin
		side_a_in.neg  = neg_s2;
		side_a_in.last = last_s2;
		side_a_in.sat  = |p_s2[63:58];
		side_a_in.y    = p_s2[57:8];
	end

	apq_isqrt_pipe u_sqrt_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_s2),
		.in_radicand (apq_pkg::SqrtW'(p_s2[57:8])),
		.in_side     (side_a_in),
		.out_valid   (vld_a),
		.out_root    (root_a),
		.out_side    (side_a_out)
	);

	// Stage 3: partial products of Y * S.
	logic               vld_s3;
	apq_pkg::apq_side_t side_s3;
	logic [42:0]        ph_s3;
	logic [56:0]        pl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_a;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_a_out;
		ph_s3   <= 43'(side_a_out.y[49:32]) * 43'(root_a[24:0]);
		pl_s3   <= 57'(side_a_out.y[31:0]) * 57'(root_a[24:0]);
	end

	// Stage 4: T = floor(Y * S / 2^16).
	logic                      vld_s4;
	apq_pkg::apq_side_t        side_s4;
	logic [apq_pkg::SqrtW-1:0] t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		t_s4    <= (apq_pkg::SqrtW'(ph_s3) << 16) + apq_pkg::SqrtW'(pl_s3[56:16]);
	end

	// Second square root: Z = isqrt(T).
	apq_pkg::apq_side_t        side_b_out;
	logic                      vld_b;
	logic [apq_pkg::RootW-1:0] root_b;

	apq_isqrt_pipe u_sqrt_t (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_s4),
		.in_radicand (t_s4),
		.in_side     (side_s4),
		.out_valid   (vld_b),
		.out_root    (root_b),
		.out_side    (side_b_out)
	);

	// Stage 5: rounding, clipping and sign.
	logic [30:0] sum;
	logic [14:0] q_raw;
	logic        clip;
	logic [13:0] q_mag;

	always_comb begin
		sum   = 31'(root_b) + 31'(round_offset_q);
		q_raw = sum[30:16];
		clip  = side_b_out.sat || (q_raw > apq_pkg::QMax);
		q_mag = clip ? apq_pkg::QMax[13:0] : q_raw[13:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		quant_value <= side_b_out.neg ? -$signed(q_mag) : $signed(q_mag);
		saturated   <= clip;
		last_out    <= side_b_out.last;
	end

	// Checks on latency and clipping.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##65 result_valid)
		else $error("result strobe missing after fixed latency");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> (quant_value == 14'sd8191 ||
			quant_value == -14'sd8191))
		else $error("saturated result not at full scale");

	a_zero_unsat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && quant_value == 14'sd0 |-> !saturated)
		else $error("zero result flagged as saturated");

endmodule
